// ----- rtl/affine_tiled_background_pixel_fetch_defines.svh -----
// Assertion macros shared by the pixel fetch RTL.
`ifndef AFFINE_TILED_BACKGROUND_PIXEL_FETCH_DEFINES_SVH
`define AFFINE_TILED_BACKGROUND_PIXEL_FETCH_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define ATBG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define ATBG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/atbg_pkg.sv -----
// Types, constants and codes of the affine background pixel fetch.
package atbg_pkg;

	localparam int MAP_TILES_PER_SIDE = 64;
	localparam int TILE_COUNT         = 256;

	localparam int TILE_SIDE      = 8;
	localparam int TILE_SIDE_BITS = $clog2(TILE_SIDE);
	localparam int MAP_SIDE_BITS  = $clog2(MAP_TILES_PER_SIDE);
	localparam int COORD_BITS     = MAP_SIDE_BITS + TILE_SIDE_BITS;
	localparam int TILE_BITS      = $clog2(TILE_COUNT);

	localparam int MAP_DEPTH  = MAP_TILES_PER_SIDE * MAP_TILES_PER_SIDE;
	localparam int TILE_DEPTH = TILE_COUNT * TILE_SIDE * TILE_SIDE;
	localparam int PAL_DEPTH  = 256;
	localparam int MAP_AW     = $clog2(MAP_DEPTH);
	localparam int TILE_AW    = $clog2(TILE_DEPTH);
	localparam int PAL_AW     = $clog2(PAL_DEPTH);

	localparam int MAP_DW  = 8;
	localparam int TILE_DW = 8;
	localparam int PAL_DW  = 15;
	localparam int CHAN_BITS = 5;

	localparam int KIND_BITS   = 2;
	localparam int ADDR_BITS   = 14;
	localparam int WDATA_BITS  = 15;
	localparam int SCREEN_BITS = 9;
	localparam int COLOR_BITS  = 8;

	localparam int COEF_BITS  = 16;
	localparam int OFF_BITS   = 28;
	localparam int CFG_IDX_BITS = 3;
	localparam int FRAC_BITS  = 8;
	localparam int PROD_BITS  = COEF_BITS + SCREEN_BITS + 1;
	// Only the bits up to the wrapped integer part matter.
	localparam int SUM_BITS   = COORD_BITS + FRAC_BITS;

	localparam logic [COEF_BITS-1:0] PA_RESET = 16'sd256;
	localparam logic [COEF_BITS-1:0] PB_RESET = 16'sd0;
	localparam logic [COEF_BITS-1:0] PC_RESET = 16'sd0;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_RENDER = 2'd0,
		KIND_MAP_WR = 2'd1,
		KIND_TILE_WR = 2'd2,
		KIND_PAL_WR = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PA       = 3'd0,
		CFG_PB       = 3'd1,
		CFG_PC       = 3'd2,
		CFG_PD       = 3'd3,
		CFG_OFFSET_X = 3'd4,
		CFG_OFFSET_Y = 3'd5
	} cfg_reg_t;

endpackage

// ----- rtl/atbg_ram.sv -----
// Generic single-port RAM with enable and registered read.
module atbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds whenever en is low, so a stalled stage keeps its word.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- rtl/affine_tiled_background_pixel_fetch.sv -----
// Affine tiled background pixel fetch, 8 bits per pixel, five-stage pipeline.
//
// Input channel (in_valid / in_stall) carries one word per cycle unless
// stalled: a render request (col, row) or a write into the map, tile or
// palette store (addr, wdata). Writes out of a store's range are dropped.
// Output channel (out_valid / out_stall) carries red, green, blue and
// color_index for each render word, in order; write words give no output.
// A render word passes the product, map, tile, palette and result registers
// in order before it shows on out_valid. Throughput is one word per clock
// while out_stall is low; each of the three stores is read or written once
// per word, each in a stage of its own, so the stores never limit the rate.
// Configuration (cfg_we, cfg_index, cfg_data) loads pa, pb, pc, offset_x
// and offset_y (pd is not stored); write it only while the pipeline is empty.
// Reset clears all valid bits and loads the default coefficients (pa 1.0,
// pb and pc zero, offsets zero). Store contents are undefined until written.
// When the receiver stalls, the result register holds; earlier stages keep
// filling their empty slots, and in_stall rises only once every stage holds
// a word.
`include "affine_tiled_background_pixel_fetch_defines.svh"

module affine_tiled_background_pixel_fetch
	import atbg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [KIND_BITS-1:0]    kind,
	input  logic [ADDR_BITS-1:0]    addr,
	input  logic [WDATA_BITS-1:0]   wdata,
	input  logic [SCREEN_BITS-1:0]  col,
	input  logic [SCREEN_BITS-1:0]  row,

	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COLOR_BITS-1:0]   red,
	output logic [COLOR_BITS-1:0]   green,
	output logic [COLOR_BITS-1:0]   blue,
	output logic [COLOR_BITS-1:0]   color_index,

	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [OFF_BITS-1:0]     cfg_data
);

	// configuration
	logic signed [COEF_BITS-1:0] pa_q, pb_q, pc_q;
	logic [OFF_BITS-1:0]         off_x_q, off_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q    <= PA_RESET;
			pb_q    <= PB_RESET;
			pc_q    <= PC_RESET;
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PA:       pa_q    <= cfg_data[COEF_BITS-1:0];
				CFG_PB:       pb_q    <= cfg_data[COEF_BITS-1:0];
				CFG_PC:       pc_q    <= cfg_data[COEF_BITS-1:0];
				CFG_PD:       ;  // not stored; the y sum has no row term
				CFG_OFFSET_X: off_x_q <= cfg_data;
				CFG_OFFSET_Y: off_y_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	kind_t kind_s4;

	assign rdy5 = !valid_s5 || !out_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4 && (kind_s4 == KIND_RENDER);
		end
	end

	// stage 1: products
	logic signed [PROD_BITS-1:0] prod_x0, prod_x1, prod_y;
	logic [SUM_BITS-1:0]         px0_s1, px1_s1, py_s1;
	kind_t                       kind_s1;
	logic [ADDR_BITS-1:0]        addr_s1;
	logic [WDATA_BITS-1:0]       wdata_s1;

	assign prod_x0 = PROD_BITS'(pa_q) * PROD_BITS'($signed({1'b0, col}));
	assign prod_x1 = PROD_BITS'(pb_q) * PROD_BITS'($signed({1'b0, row}));
	assign prod_y  = PROD_BITS'(pc_q) * PROD_BITS'($signed({1'b0, col}));

	always_ff @(posedge clk) begin
		if (rdy1) begin
			px0_s1   <= prod_x0[SUM_BITS-1:0];
			px1_s1   <= prod_x1[SUM_BITS-1:0];
			py_s1    <= prod_y[SUM_BITS-1:0];
			kind_s1  <= kind_t'(kind);
			addr_s1  <= addr;
			wdata_s1 <= wdata;
		end
	end

	// stage 2: source point, map access
	logic [SUM_BITS-1:0]   sx_sum, sy_sum;
	logic [COORD_BITS-1:0] sx, sy;
	logic [MAP_AW-1:0]     map_addr;
	logic                  map_we;
	logic [MAP_DW-1:0]     map_rdata;

	// low bits of a two's complement sum give floor(s/256) mod span directly
	assign sx_sum = px0_s1 + px1_s1 + off_x_q[SUM_BITS-1:0];
	assign sy_sum = py_s1 + off_y_q[SUM_BITS-1:0];
	assign sx     = sx_sum[SUM_BITS-1:FRAC_BITS];
	assign sy     = sy_sum[SUM_BITS-1:FRAC_BITS];

	assign map_we   = (kind_s1 == KIND_MAP_WR) && ({1'b0, addr_s1} < (ADDR_BITS+1)'(MAP_DEPTH));
	assign map_addr = (kind_s1 == KIND_RENDER)
		? {sy[COORD_BITS-1:TILE_SIDE_BITS], sx[COORD_BITS-1:TILE_SIDE_BITS]}
		: addr_s1[MAP_AW-1:0];

	atbg_ram #(.WIDTH(MAP_DW), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.en    (rdy2 && valid_s1),
		.we    (map_we),
		.addr  (map_addr),
		.wdata (wdata_s1[MAP_DW-1:0]),
		.rdata (map_rdata)
	);

	kind_t                     kind_s2;
	logic [ADDR_BITS-1:0]      addr_s2;
	logic [WDATA_BITS-1:0]     wdata_s2;
	logic [TILE_SIDE_BITS-1:0] sub_x_s2, sub_y_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			kind_s2  <= kind_s1;
			addr_s2  <= addr_s1;
			wdata_s2 <= wdata_s1;
			sub_x_s2 <= sx[TILE_SIDE_BITS-1:0];
			sub_y_s2 <= sy[TILE_SIDE_BITS-1:0];
		end
	end

	// stage 3: tile access
	logic [TILE_AW-1:0] tile_addr;
	logic               tile_we;
	logic [TILE_DW-1:0] tile_rdata;

	assign tile_we   = (kind_s2 == KIND_TILE_WR) &&
		({1'b0, addr_s2} < (ADDR_BITS+1)'(TILE_DEPTH));
	assign tile_addr = (kind_s2 == KIND_RENDER)
		? {map_rdata[TILE_BITS-1:0], sub_y_s2, sub_x_s2}
		: addr_s2[TILE_AW-1:0];

	atbg_ram #(.WIDTH(TILE_DW), .DEPTH(TILE_DEPTH)) u_tile_ram (
		.clk   (clk),
		.en    (rdy3 && valid_s2),
		.we    (tile_we),
		.addr  (tile_addr),
		.wdata (wdata_s2[TILE_DW-1:0]),
		.rdata (tile_rdata)
	);

	kind_t                 kind_s3;
	logic [ADDR_BITS-1:0]  addr_s3;
	logic [WDATA_BITS-1:0] wdata_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			kind_s3  <= kind_s2;
			addr_s3  <= addr_s2;
			wdata_s3 <= wdata_s2;
		end
	end

	// stage 4: palette access
	logic [PAL_AW-1:0] pal_addr;
	logic              pal_we;
	logic [PAL_DW-1:0] pal_rdata;

	assign pal_we   = (kind_s3 == KIND_PAL_WR) && ({1'b0, addr_s3} < (ADDR_BITS+1)'(PAL_DEPTH));
	assign pal_addr = (kind_s3 == KIND_RENDER) ? tile_rdata[PAL_AW-1:0] : addr_s3[PAL_AW-1:0];

	atbg_ram #(.WIDTH(PAL_DW), .DEPTH(PAL_DEPTH)) u_pal_ram (
		.clk   (clk),
		.en    (rdy4 && valid_s3),
		.we    (pal_we),
		.addr  (pal_addr),
		.wdata (wdata_s3[PAL_DW-1:0]),
		.rdata (pal_rdata)
	);

	logic [TILE_DW-1:0]  idx_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			kind_s4 <= kind_s3;
			idx_s4  <= tile_rdata;
		end
	end

	// stage 5: result register; index zero is black without the palette
	logic [PAL_DW-1:0] color;

	assign color = (idx_s4 == '0) ? '0 : pal_rdata;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			red         <= {color[CHAN_BITS-1:0], 3'b000};
			green       <= {color[2*CHAN_BITS-1:CHAN_BITS], 3'b000};
			blue        <= {color[3*CHAN_BITS-1:2*CHAN_BITS], 3'b000};
			color_index <= idx_s4;
		end
	end

	assign out_valid = valid_s5;

	`ATBG_ASSERT_NOW(a_black_on_zero, out_valid && color_index == '0,
		red == '0 && green == '0 && blue == '0, "nonzero color for index zero")
	`ATBG_ASSERT_NOW(a_stall_only_full, in_stall,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall,
		"input stalled with an empty slot in the pipeline")
	`ATBG_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, valid_s1,
		"accepted word missing from stage 1")
	`ATBG_ASSERT_NEXT(a_s2_holds, valid_s2 && !rdy3,
		valid_s2 && $stable(kind_s2) && $stable(sub_x_s2) && $stable(sub_y_s2),
		"blocked stage 2 word changed")

endmodule
